// ----- hdl/ildt_pkg.sv -----
// Shared types and constants for the interrupt line dispatch table.
`timescale 1ns / 1ps
package ildt_pkg;
   typedef enum logic [2:0] {
      KIND_INSTALL = 3'd0, KIND_REMOVE = 3'd1, KIND_ADD = 3'd2, KIND_DROP = 3'd3,
      KIND_SUB = 3'd4, KIND_UNSUB = 3'd5, KIND_RAISE = 3'd6, KIND_POST = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE = 3'd0, ACT_PRIMARY = 3'd1, ACT_SHARED = 3'd2, ACT_DELIVER = 3'd3,
      ACT_EOI = 3'd4, ACT_UNMASK = 3'd5, ACT_MASK = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_REJECT = 2'd1, ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_SCAN, BK_DONE
   } back_state_type;

   localparam int PRIMARY_LINES = 16;
   localparam int VECTOR_BASE = 32;
   localparam int VECTOR_END = 48;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  number;
      logic [7:0]  line;
      logic        direct;
      status_type  status;
      action_type  action;
      logic [15:0] handler_id;
      logic [15:0] context_id;
      logic [7:0]  mailbox_id;
      logic [31:0] event_data;
      logic [31:0] tick;
   } cmd_type;
endpackage

// ----- hdl/irq_line_dispatch_table_top.sv -----
// Top level of the interrupt line dispatch table.
`timescale 1ns / 1ps
// Commands enter on start while busy is low and go through a two-entry queue
// to the back end; busy is high only while that queue is full. The back end
// takes a command from the queue, which also reads the line's slot row, then
// walks the slots one per cycle, closes the walk and ends with the closing
// result. A primary command or a rejected or out-of-range command skips the
// walk; a shared table command walks SHARED_SLOTS slots, a subscription
// command or a posted event MAILBOX_SLOTS slots, and a raise looks up the
// primary handler before it walks the shared slots. Results appear one per
// cycle on rsp_valid with rsp_last on the final one; the receiver cannot
// stall them. A posted event with subscribers marks its final delivery as
// last; without subscribers it gives one closing result.
module irq_line_dispatch_table_top #(
   parameter int LINE_COUNT = 16,
   parameter int SHARED_SLOTS = 4,
   parameter int MAILBOX_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_number,
   input  logic [15:0] req_handler_id,
   input  logic [15:0] req_context_id,
   input  logic [7:0]  req_mailbox_id,
   input  logic [31:0] req_event_data,
   input  logic [31:0] req_tick,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_action,
   output logic [15:0] rsp_target_handler,
   output logic [15:0] rsp_target_context,
   output logic [7:0]  rsp_target_mailbox,
   output logic [7:0]  rsp_line,
   output logic [31:0] rsp_delivered_data,
   output logic [31:0] rsp_delivered_tick,
   output logic        rsp_last
);
   import ildt_pkg::*;

   cmd_type fcmd, head;
   logic    q_empty, q_full, q_pop, back_busy;

   ildt_front #(.LINE_COUNT(LINE_COUNT)) u_front (
      .kind(req_kind), .number(req_number), .handler_id(req_handler_id),
      .context_id(req_context_id), .mailbox_id(req_mailbox_id),
      .event_data(req_event_data), .tick(req_tick), .cmd(fcmd)
   );

   ildt_queue u_queue (
      .clock(clock), .reset(reset), .push(start && !busy), .push_cmd(fcmd),
      .pop(q_pop), .empty(q_empty), .full(q_full), .head(head)
   );

   ildt_back #(
      .LINE_COUNT(LINE_COUNT), .SHARED_SLOTS(SHARED_SLOTS), .MAILBOX_SLOTS(MAILBOX_SLOTS)
   ) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_head(head), .q_pop(q_pop),
      .busy(back_busy), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_action(rsp_action), .rsp_target_handler(rsp_target_handler),
      .rsp_target_context(rsp_target_context), .rsp_target_mailbox(rsp_target_mailbox),
      .rsp_line(rsp_line), .rsp_delivered_data(rsp_delivered_data),
      .rsp_delivered_tick(rsp_delivered_tick), .rsp_last(rsp_last)
   );

   assign busy = q_full || back_busy;
endmodule

// ----- hdl/ildt_front.sv -----
// Front end: range and null checks and output line for each command.
`timescale 1ns / 1ps
module ildt_front #(
   parameter int LINE_COUNT = 16
) (
   input  logic [2:0]       kind,
   input  logic [7:0]       number,
   input  logic [15:0]      handler_id,
   input  logic [15:0]      context_id,
   input  logic [7:0]       mailbox_id,
   input  logic [31:0]      event_data,
   input  logic [31:0]      tick,
   output ildt_pkg::cmd_type cmd
);
   import ildt_pkg::*;

   always_comb begin
      cmd = '0;
      cmd.kind = kind_type'(kind);
      cmd.number = number;
      cmd.line = number;
      cmd.handler_id = handler_id;
      cmd.context_id = context_id;
      cmd.mailbox_id = mailbox_id;
      cmd.event_data = event_data;
      cmd.tick = tick;
      cmd.status = ST_OK;
      cmd.action = ACT_NONE;
      cmd.direct = 1'b0;
      unique case (kind_type'(kind))
         KIND_INSTALL, KIND_REMOVE: begin
            cmd.direct = 1'b1;
            if (number >= 8'(PRIMARY_LINES)) begin
               cmd.status = ST_RANGE;
            end else begin
               cmd.action = (kind_type'(kind) == KIND_INSTALL) ? ACT_UNMASK : ACT_MASK;
            end
         end
         KIND_ADD, KIND_DROP: begin
            if (number >= 8'(LINE_COUNT)) begin
               cmd.direct = 1'b1;
               cmd.status = ST_RANGE;
            end else if (handler_id == '0) begin
               cmd.direct = 1'b1;
               cmd.status = ST_REJECT;
            end
         end
         KIND_SUB, KIND_UNSUB: begin
            if (number >= 8'(LINE_COUNT)) begin
               cmd.direct = 1'b1;
               cmd.status = ST_RANGE;
            end else if (mailbox_id == '0) begin
               cmd.direct = 1'b1;
               cmd.status = ST_REJECT;
            end
         end
         KIND_RAISE: begin
            if (number < 8'(VECTOR_BASE) || number >= 8'(VECTOR_END)) begin
               cmd.direct = 1'b1;
               cmd.status = ST_RANGE;
            end else begin
               cmd.line = number - 8'(VECTOR_BASE);
            end
         end
         default: begin
            if (number >= 8'(LINE_COUNT)) begin
               cmd.direct = 1'b1;
               cmd.status = ST_RANGE;
            end
         end
      endcase
   end
endmodule

// ----- hdl/ildt_queue.sv -----
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
module ildt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ildt_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              empty,
   output logic              full,
   output ildt_pkg::cmd_type head
);
   import ildt_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full = (cnt_ff == 2'd2);
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end
endmodule

// ----- hdl/ildt_back.sv -----
// Back end: table storage, slot scans and result sequencing.
`timescale 1ns / 1ps
module ildt_back #(
   parameter int LINE_COUNT = 16,
   parameter int SHARED_SLOTS = 4,
   parameter int MAILBOX_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ildt_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              busy,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [2:0]        rsp_action,
   output logic [15:0]       rsp_target_handler,
   output logic [15:0]       rsp_target_context,
   output logic [7:0]        rsp_target_mailbox,
   output logic [7:0]        rsp_line,
   output logic [31:0]       rsp_delivered_data,
   output logic [31:0]       rsp_delivered_tick,
   output logic              rsp_last
);
   import ildt_pkg::*;

   localparam int LW = $clog2(LINE_COUNT);
   localparam int SLOTS = (SHARED_SLOTS > MAILBOX_SLOTS) ? SHARED_SLOTS : MAILBOX_SLOTS;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int SRW = SHARED_SLOTS * 32;
   localparam int BRW = MAILBOX_SLOTS * 8;

   logic [15:0]           prim_ff [PRIMARY_LINES];
   logic [SRW-1:0]        sh_mem_ff [LINE_COUNT];
   logic [BRW-1:0]        bx_mem_ff [LINE_COUNT];
   logic [LINE_COUNT-1:0] sh_vld_ff, bx_vld_ff;
   logic [SRW-1:0]        sh_rd_ff, sh_row, sh_new;
   logic [BRW-1:0]        bx_rd_ff, bx_row, bx_new;
   logic                  sh_rv_ff, bx_rv_ff;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           hit_ff, hit_in, free_ok_ff, free_ok_in, any_ff, any_in;
   logic [SW-1:0]  hit_at_ff, hit_at_in, free_at_ff, free_at_in;
   logic           prim_done_ff, prim_done_in;

   logic [LW-1:0]  li, qi;
   logic [CW-1:0]  nslots;
   logic           cur_used, cur_match, do_emit, emit_last;
   logic [15:0]    cur_h, cur_c;
   logic [7:0]     cur_b;
   logic [SW-1:0]  si;
   logic           emit_now;
   logic           is_shared;
   logic           later_used;

   assign li = cmd_ff.line[LW-1:0];
   assign qi = q_head.line[LW-1:0];
   assign si = idx_ff[SW-1:0];
   assign is_shared = (cmd_ff.kind == KIND_ADD || cmd_ff.kind == KIND_DROP ||
                       cmd_ff.kind == KIND_RAISE);
   assign nslots = is_shared ? CW'(SHARED_SLOTS) : CW'(MAILBOX_SLOTS);
   assign sh_row = sh_rv_ff ? sh_rd_ff : '0;
   assign bx_row = bx_rv_ff ? bx_rd_ff : '0;

   always_comb begin
      cur_h = '0;
      cur_c = '0;
      cur_b = '0;
      if (idx_ff < nslots) begin
         if (is_shared) begin
            cur_h = sh_row[int'(si) * 32 + 16 +: 16];
            cur_c = sh_row[int'(si) * 32 +: 16];
         end else begin
            cur_b = bx_row[int'(si) * 8 +: 8];
         end
      end
      cur_used = is_shared ? (cur_h != '0) : (cur_b != '0);
      cur_match = is_shared ? (cur_h == cmd_ff.handler_id && cur_c == cmd_ff.context_id)
                            : (cur_b == cmd_ff.mailbox_id);
   end

   always_comb begin
      later_used = 1'b0;
      for (int s = 0; s < MAILBOX_SLOTS; s++) begin
         if (CW'(s) > idx_ff && bx_row[s * 8 +: 8] != '0) begin
            later_used = 1'b1;
         end
      end
   end

   always_comb begin
      sh_new = sh_row;
      bx_new = bx_row;
      case (cmd_ff.kind)
         KIND_ADD: if (!hit_ff && free_ok_ff) begin
            sh_new[int'(free_at_ff) * 32 +: 32] = {cmd_ff.handler_id, cmd_ff.context_id};
         end
         KIND_DROP: if (hit_ff) begin
            sh_new[int'(hit_at_ff) * 32 +: 32] = '0;
         end
         KIND_SUB: if (!hit_ff && free_ok_ff) begin
            bx_new[int'(free_at_ff) * 8 +: 8] = cmd_ff.mailbox_id;
         end
         KIND_UNSUB: if (hit_ff) begin
            bx_new[int'(hit_at_ff) * 8 +: 8] = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hit_at_in = hit_at_ff;
      free_ok_in = free_ok_ff;
      free_at_in = free_at_ff;
      any_in = any_ff;
      prim_done_in = prim_done_ff;
      q_pop = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               idx_in = '0;
               hit_in = 1'b0;
               free_ok_in = 1'b0;
               any_in = 1'b0;
               prim_done_in = 1'b0;
               state_in = q_head.direct ? BK_DONE : BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (cmd_ff.kind == KIND_RAISE && !prim_done_ff) begin
               prim_done_in = 1'b1;
            end else if (idx_ff < nslots) begin
               idx_in = idx_ff + CW'(1);
               if (!hit_ff && cur_used && cur_match) begin
                  hit_in = 1'b1;
                  hit_at_in = si;
               end
               if (!free_ok_ff && !cur_used) begin
                  free_ok_in = 1'b1;
                  free_at_in = si;
               end
               if (cur_used) begin
                  any_in = 1'b1;
               end
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign busy = 1'b0;

   always_comb begin
      do_emit = 1'b0;
      emit_last = 1'b0;
      emit_now = 1'b0;
      rsp_status = ST_OK;
      rsp_action = ACT_NONE;
      rsp_target_handler = '0;
      rsp_target_context = '0;
      rsp_target_mailbox = '0;
      rsp_line = cmd_ff.line;
      rsp_delivered_data = '0;
      rsp_delivered_tick = '0;
      if (state_ff == BK_SCAN) begin
         if (cmd_ff.kind == KIND_RAISE) begin
            if (!prim_done_ff) begin
               do_emit = (prim_ff[cmd_ff.line[3:0]] != '0);
               rsp_action = ACT_PRIMARY;
               rsp_target_handler = prim_ff[cmd_ff.line[3:0]];
            end else if (idx_ff < nslots && cur_used) begin
               do_emit = 1'b1;
               rsp_action = ACT_SHARED;
               rsp_target_handler = cur_h;
               rsp_target_context = cur_c;
            end
         end else if (cmd_ff.kind == KIND_POST && idx_ff < nslots && cur_used) begin
            do_emit = 1'b1;
            emit_last = !later_used;
            rsp_action = ACT_DELIVER;
            rsp_target_mailbox = cur_b;
            rsp_delivered_data = cmd_ff.event_data;
            rsp_delivered_tick = cmd_ff.tick;
         end
      end else if (state_ff == BK_DONE) begin
         do_emit = 1'b1;
         emit_last = 1'b1;
         rsp_status = cmd_ff.status;
         rsp_action = cmd_ff.action;
         if (!cmd_ff.direct) begin
            case (cmd_ff.kind)
               KIND_ADD, KIND_SUB: begin
                  if (hit_ff) begin
                     rsp_action = ACT_NONE;
                  end else if (free_ok_ff) begin
                     rsp_action = ACT_UNMASK;
                  end else begin
                     rsp_status = ST_REJECT;
                  end
               end
               KIND_DROP, KIND_UNSUB: begin
                  if (!hit_ff) begin
                     rsp_status = ST_REJECT;
                  end
               end
               KIND_RAISE: rsp_action = ACT_EOI;
               default: begin
                  if (any_ff) begin
                     do_emit = 1'b0;
                  end
               end
            endcase
         end
      end
      emit_now = do_emit;
      rsp_valid = emit_now;
      rsp_last = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      hit_at_ff <= hit_at_in;
      free_ok_ff <= free_ok_in;
      free_at_ff <= free_at_in;
      any_ff <= any_in;
      prim_done_ff <= prim_done_in;
      if (q_pop) begin
         cmd_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < PRIMARY_LINES; l++) prim_ff[l] <= '0;
         sh_vld_ff <= '0;
         bx_vld_ff <= '0;
      end else if (state_ff == BK_DONE) begin
         if (cmd_ff.direct) begin
            if (cmd_ff.status == ST_OK &&
                (cmd_ff.kind == KIND_INSTALL || cmd_ff.kind == KIND_REMOVE)) begin
               prim_ff[cmd_ff.number[3:0]] <=
                  (cmd_ff.kind == KIND_INSTALL) ? cmd_ff.handler_id : '0;
            end
         end else if (cmd_ff.kind == KIND_ADD || cmd_ff.kind == KIND_DROP) begin
            sh_vld_ff[li] <= 1'b1;
         end else if (cmd_ff.kind == KIND_SUB || cmd_ff.kind == KIND_UNSUB) begin
            bx_vld_ff[li] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sh_rd_ff <= sh_mem_ff[qi];
         bx_rd_ff <= bx_mem_ff[qi];
         sh_rv_ff <= sh_vld_ff[qi];
         bx_rv_ff <= bx_vld_ff[qi];
      end
      if (state_ff == BK_DONE && !cmd_ff.direct) begin
         if (cmd_ff.kind == KIND_ADD || cmd_ff.kind == KIND_DROP) begin
            sh_mem_ff[li] <= sh_new;
         end
         if (cmd_ff.kind == KIND_SUB || cmd_ff.kind == KIND_UNSUB) begin
            bx_mem_ff[li] <= bx_new;
         end
      end
   end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the interrupt line dispatch table: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
module tb;
   import ildt_pkg::*;

   localparam int LINES = 16;
   localparam int SSLOTS = 4;
   localparam int MSLOTS = 4;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  action;
      logic [15:0] handler;
      logic [15:0] context_id;
      logic [7:0]  mailbox;
      logic [7:0]  line;
      logic [31:0] data;
      logic [31:0] tick;
      logic        last;
   } result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_number = '0;
   logic [15:0] req_handler_id = '0;
   logic [15:0] req_context_id = '0;
   logic [7:0]  req_mailbox_id = '0;
   logic [31:0] req_event_data = '0;
   logic [31:0] req_tick = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_action;
   logic [15:0] rsp_target_handler;
   logic [15:0] rsp_target_context;
   logic [7:0]  rsp_target_mailbox;
   logic [7:0]  rsp_line;
   logic [31:0] rsp_delivered_data;
   logic [31:0] rsp_delivered_tick;
   logic        rsp_last;

   logic [15:0] primary_handlers [LINES];
   logic [15:0] shared_handlers [LINES][SSLOTS];
   logic [15:0] shared_contexts [LINES][SSLOTS];
   logic [7:0]  mailboxes [LINES][MSLOTS];
   result_type pending_results [$];
   int  mismatches = 0;
   int  idle_pct = 0;
   longint cycles = 0;

   irq_line_dispatch_table_top i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic result_type mk(logic [1:0] st, logic [2:0] act, logic [15:0] h,
                                     logic [15:0] c, logic [7:0] m, logic [7:0] ln,
                                     logic [31:0] d, logic [31:0] t);
      result_type r;
      r = '{st, act, h, c, m, ln, d, t, 1'b0};
      return r;
   endfunction

   task automatic predict_dispatch(logic [2:0] kind, logic [7:0] num, logic [15:0] hnd,
                                   logic [15:0] ctx, logic [7:0] box, logic [31:0] data,
                                   logic [31:0] tck);
      result_type outs [$];
      int hit, free_slot;
      logic [7:0] ln;
      hit = -1;
      free_slot = -1;
      case (kind)
         KIND_INSTALL, KIND_REMOVE: begin
            if (num >= PRIMARY_LINES) outs.push_back(mk(ST_RANGE, ACT_NONE, 0, 0, 0, num, 0, 0));
            else if (kind == KIND_INSTALL) begin
               primary_handlers[num] = hnd;
               outs.push_back(mk(ST_OK, ACT_UNMASK, 0, 0, 0, num, 0, 0));
            end else begin
               primary_handlers[num] = 0;
               outs.push_back(mk(ST_OK, ACT_MASK, 0, 0, 0, num, 0, 0));
            end
         end
         KIND_ADD, KIND_DROP: begin
            if (num >= LINES) outs.push_back(mk(ST_RANGE, ACT_NONE, 0, 0, 0, num, 0, 0));
            else if (hnd == 0) outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
            else begin
               for (int i = 0; i < SSLOTS; i++) begin
                  if (hit < 0 && shared_handlers[num][i] == hnd && shared_contexts[num][i] == ctx)
                     hit = i;
                  if (free_slot < 0 && shared_handlers[num][i] == 0) free_slot = i;
               end
               if (kind == KIND_ADD) begin
                  if (hit >= 0) outs.push_back(mk(ST_OK, ACT_NONE, 0, 0, 0, num, 0, 0));
                  else if (free_slot >= 0) begin
                     shared_handlers[num][free_slot] = hnd;
                     shared_contexts[num][free_slot] = ctx;
                     outs.push_back(mk(ST_OK, ACT_UNMASK, 0, 0, 0, num, 0, 0));
                  end else outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
               end else if (hit >= 0) begin
                  shared_handlers[num][hit] = 0;
                  shared_contexts[num][hit] = 0;
                  outs.push_back(mk(ST_OK, ACT_NONE, 0, 0, 0, num, 0, 0));
               end else outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
            end
         end
         KIND_SUB, KIND_UNSUB: begin
            if (num >= LINES) outs.push_back(mk(ST_RANGE, ACT_NONE, 0, 0, 0, num, 0, 0));
            else if (box == 0) outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
            else begin
               for (int i = 0; i < MSLOTS; i++) begin
                  if (hit < 0 && mailboxes[num][i] == box) hit = i;
                  if (free_slot < 0 && mailboxes[num][i] == 0) free_slot = i;
               end
               if (kind == KIND_SUB) begin
                  if (hit >= 0) outs.push_back(mk(ST_OK, ACT_NONE, 0, 0, 0, num, 0, 0));
                  else if (free_slot >= 0) begin
                     mailboxes[num][free_slot] = box;
                     outs.push_back(mk(ST_OK, ACT_UNMASK, 0, 0, 0, num, 0, 0));
                  end else outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
               end else if (hit >= 0) begin
                  mailboxes[num][hit] = 0;
                  outs.push_back(mk(ST_OK, ACT_NONE, 0, 0, 0, num, 0, 0));
               end else outs.push_back(mk(ST_REJECT, ACT_NONE, 0, 0, 0, num, 0, 0));
            end
         end
         KIND_RAISE: begin
            if (num < VECTOR_BASE || num >= VECTOR_END)
               outs.push_back(mk(ST_RANGE, ACT_NONE, 0, 0, 0, num, 0, 0));
            else begin
               ln = 8'(num - VECTOR_BASE);
               if (primary_handlers[ln[3:0]] != 0)
                  outs.push_back(mk(ST_OK, ACT_PRIMARY, primary_handlers[ln[3:0]], 0, 0, ln,
                                    0, 0));
               if (ln < LINES)
                  for (int i = 0; i < SSLOTS; i++)
                     if (shared_handlers[ln[3:0]][i] != 0)
                        outs.push_back(mk(ST_OK, ACT_SHARED, shared_handlers[ln[3:0]][i],
                                          shared_contexts[ln[3:0]][i], 0, ln, 0, 0));
               outs.push_back(mk(ST_OK, ACT_EOI, 0, 0, 0, ln, 0, 0));
            end
         end
         default: begin
            if (num >= LINES) outs.push_back(mk(ST_RANGE, ACT_NONE, 0, 0, 0, num, 0, 0));
            else begin
               for (int i = 0; i < MSLOTS; i++)
                  if (mailboxes[num][i] != 0)
                     outs.push_back(mk(ST_OK, ACT_DELIVER, 0, 0, mailboxes[num][i], num,
                                       data, tck));
               if (outs.size() == 0) outs.push_back(mk(ST_OK, ACT_NONE, 0, 0, 0, num, 0, 0));
            end
         end
      endcase
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) pending_results.push_back(outs[i]);
   endtask

   task automatic issue_command(logic [2:0] kind, logic [7:0] num, logic [15:0] hnd,
                                logic [15:0] ctx, logic [7:0] box, logic [31:0] data,
                                logic [31:0] tck);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_number <= num;
      req_handler_id <= hnd;
      req_context_id <= ctx;
      req_mailbox_id <= box;
      req_event_data <= data;
      req_tick <= tck;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_dispatch(kind, num, hnd, ctx, box, data, tck);
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_action, rsp_target_handler, rsp_target_context,
                 rsp_target_mailbox, rsp_line, rsp_delivered_data, rsp_delivered_tick,
                 rsp_last};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      issue_command(KIND_INSTALL, 0, 16'hFFFF, 0, 0, 0, 0);
      issue_command(KIND_INSTALL, 15, 16'h0001, 0, 0, 0, 0);
      issue_command(KIND_INSTALL, 16, 16'h1234, 0, 0, 0, 0);
      issue_command(KIND_REMOVE, 255, 0, 0, 0, 0, 0);
      issue_command(KIND_ADD, 0, 0, 16'h5, 0, 0, 0);
      for (int i = 1; i <= 5; i++)
         issue_command(KIND_ADD, 0, 16'(16'hFFFF - i), 16'(i), 0, 0, 0);
      issue_command(KIND_ADD, 0, 16'hFFFE, 1, 0, 0, 0);
      issue_command(KIND_ADD, 16, 16'h7, 0, 0, 0, 0);
      issue_command(KIND_RAISE, 32, 0, 0, 0, 0, 0);
      issue_command(KIND_RAISE, 47, 0, 0, 0, 0, 0);
      issue_command(KIND_RAISE, 31, 0, 0, 0, 0, 0);
      issue_command(KIND_RAISE, 48, 0, 0, 0, 0, 0);
      issue_command(KIND_DROP, 0, 16'hFFFD, 2, 0, 0, 0);
      issue_command(KIND_DROP, 0, 16'hFFFD, 2, 0, 0, 0);
      issue_command(KIND_POST, 3, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 5; i++) issue_command(KIND_SUB, 3, 0, 0, 8'(8'hFF - i), 0, 0);
      issue_command(KIND_SUB, 3, 0, 0, 0, 0, 0);
      issue_command(KIND_POST, 3, 0, 0, 0, 32'hA5A5A5A5, 32'h5A5A5A5A);
      issue_command(KIND_UNSUB, 3, 0, 0, 8'hFE, 0, 0);
      issue_command(KIND_UNSUB, 3, 0, 0, 8'hFE, 0, 0);
      issue_command(KIND_POST, 200, 0, 0, 0, 1, 1);
      issue_command(KIND_REMOVE, 0, 0, 0, 0, 0, 0);
      drain_results();
   endtask

   task automatic test_random(int count);
      logic [2:0]  kind;
      logic [7:0]  num;
      logic [15:0] hnd, ctx;
      logic [7:0]  box;
      for (int n = 0; n < count; n++) begin
         kind = 3'($urandom_range(7));
         if ($urandom_range(9) == 0) num = 8'($urandom_range(255));
         else if (kind == KIND_RAISE) num = 8'(VECTOR_BASE + $urandom_range(15));
         else num = 8'($urandom_range(LINES - 1));
         hnd = ($urandom_range(9) == 0) ? 16'h0 :
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
         ctx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
         box = ($urandom_range(9) == 0) ? 8'h0 :
               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
         issue_command(kind, num, hnd, ctx, box, $urandom, $urandom);
      end
   endtask

   initial begin
      foreach (primary_handlers[i]) primary_handlers[i] = 0;
      foreach (shared_handlers[i, j]) begin
         shared_handlers[i][j] = 0;
         shared_contexts[i][j] = 0;
      end
      foreach (mailboxes[i, j]) mailboxes[i][j] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_pct = 0;
      test_random(150);
      drain_results();
      idle_pct = 50;
      test_random(150);
      idle_pct = 10;
      test_random(130);
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/ildt_pkg.sv
hdl/ildt_front.sv
hdl/ildt_queue.sv
hdl/ildt_back.sv
hdl/irq_line_dispatch_table_top.sv
tb/sv/tb.sv
